// ===== src/shash_pkg.sv =====
// Package: SHA-512 constants, types and round functions shared by the hasher modules.
package shash_pkg;

   localparam int unsigned BlockBytes = 128;
   localparam int unsigned Rounds     = 80;
   localparam int unsigned LenBytes   = 112;
   localparam logic [7:0]  PadByte    = 8'h80;

   typedef logic [63:0] word_type;
   typedef logic [6:0]  addr_type;

   // Commands from the controller to the datapath.
   typedef enum logic [2:0] {
      CMD_IDLE,
      CMD_WRITE,      // write a byte into the buffer at the given address
      CMD_LOAD,       // load the working registers from the hash words
      CMD_ROUND,      // one compression round
      CMD_ADD,        // fold the working registers into the hash words
      CMD_RESTART     // return hash words to their initial values
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      addr_type   addr;
      logic [7:0] wdata;
      logic [6:0] round;
      logic [2:0] out_sel;
   } dp_ctrl_type;

   function automatic word_type round_const(input logic [6:0] idx);
      word_type k [0:79];
      k = '{
         64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
         64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
         64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
         64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
         64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
         64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
         64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
         64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
         64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
         64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
         64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
         64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
         64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
         64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
         64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
         64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
         64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
         64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
         64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
         64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
      return k[idx];
   endfunction

   function automatic word_type init_hash(input logic [2:0] idx);
      word_type h [0:7];
      h = '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
            64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
            64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
      return h[idx];
   endfunction

   function automatic word_type ror(input word_type v, input int unsigned s);
      return (v >> s) | (v << (64 - s));
   endfunction

endpackage

// ===== src/shash_if.sv =====
// Interfaces: valid/ready channels for the request and response words.
interface shash_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] byte_value;
   modport source (output valid, action, byte_value, input ready);
   modport sink   (input valid, action, byte_value, output ready);
endinterface

interface shash_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== src/sha512_stream_hasher.sv =====
// Top level: SHA-512 hasher over a byte stream.
//  channel | dir | handshake        | payload
//  req     | in  | valid/ready      | action, byte_value
//  rsp     | out | valid/ready      | digest_word, word_index, last_word
// Each absorbed byte goes into the block buffer; the 128th byte of a block starts a
// compression (a byte-serial load of the block from the buffer, 80 rounds, one add).
// Finalise writes the padding one byte per cycle, compresses once or twice,
// then emits eight words, one at a time, each held until it is taken.
// The byte-wide block buffer and the one-round-per-cycle unit set this pace.
// Reset is synchronous and restores the initial hash values; req is held off while busy.
module sha512_stream_hasher
   import shash_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   shash_req_if.sink   req,
   shash_rsp_if.source rsp
);

   dp_ctrl_type ctrl;
   word_type    digest;

   shash_controller u_ctrl (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .digest_in(digest), .ctrl(ctrl)
   );

   shash_datapath u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .digest_out(digest)
   );

   // A digest word is never shown while a new word is being taken.
   assert property (@(posedge clock) disable iff (reset) !(rsp.valid && req.ready))
      else $error("response valid while request ready");

   // A stalled response keeps its index.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.word_index))
      else $error("response dropped under stall");

endmodule

// ===== src/shash_datapath.sv =====
// Datapath: block buffer, message schedule, working registers and hash words.
module shash_datapath
   import shash_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  dp_ctrl_type ctrl,
   output word_type    digest_out
);

   // Block buffer memory, written a byte at a time.
   logic [7:0] buf_mem [0:BlockBytes-1];
   // Schedule window: sixteen words shifted once a round.
   word_type   w_ff [0:15];
   word_type   r_ff [0:7];
   word_type   h_ff [0:7];
   logic [3:0] fill_word_ff;
   logic       filling_ff;
   logic [2:0] byte_idx_ff;
   word_type   gather_ff;

   // Buffer write.
   always_ff @(posedge clock) begin
      if (ctrl.cmd == CMD_WRITE) begin
         buf_mem[ctrl.addr] <= ctrl.wdata;
      end
   end

   // Read address of the schedule loader: one byte per cycle.
   logic [7:0] rd_byte_ff;
   addr_type   rd_addr;
   assign rd_addr = {fill_word_ff, byte_idx_ff};
   always_ff @(posedge clock) begin
      rd_byte_ff <= buf_mem[rd_addr];
   end

   // Schedule words: w[i] for round i is always w_ff[0].
   word_type s0, s1, w_new;
   always_comb begin
      s1 = ror(w_ff[14], 19) ^ ror(w_ff[14], 61) ^ (w_ff[14] >> 6);
      s0 = ror(w_ff[1], 1) ^ ror(w_ff[1], 8) ^ (w_ff[1] >> 7);
      w_new = s1 + w_ff[9] + s0 + w_ff[0];
   end

   // Round function.
   word_type t1, t2, ea, aa;
   always_comb begin
      ea = r_ff[4];
      aa = r_ff[0];
      t1 = r_ff[7] + (ror(ea, 14) ^ ror(ea, 18) ^ ror(ea, 41))
           + ((ea & r_ff[5]) ^ (~ea & r_ff[6])) + round_const(ctrl.round) + w_ff[0];
      t2 = (ror(aa, 28) ^ ror(aa, 34) ^ ror(aa, 39))
           + ((aa & r_ff[1]) ^ (aa & r_ff[2]) ^ (r_ff[1] & r_ff[2]));
   end

   // Loading works byte-serially during CMD_LOAD: 128 bytes, read through the registered buffer output.
   always_ff @(posedge clock) begin
      if (reset) begin
         filling_ff   <= 1'b0;
         fill_word_ff <= '0;
         byte_idx_ff  <= '0;
      end else if (ctrl.cmd == CMD_LOAD) begin
         filling_ff  <= 1'b1;
         byte_idx_ff <= byte_idx_ff + 3'd1;
         if (byte_idx_ff == 3'd7) begin
            fill_word_ff <= fill_word_ff + 4'd1;
         end
      end else begin
         filling_ff   <= 1'b0;
         fill_word_ff <= '0;
         byte_idx_ff  <= '0;
      end
   end

   // Gather bytes into words and shift into the schedule window.
   logic [2:0] gcnt_ff;
   always_ff @(posedge clock) begin
      if (ctrl.cmd == CMD_LOAD && filling_ff) begin
         gather_ff <= {gather_ff[55:0], rd_byte_ff};
         gcnt_ff   <= gcnt_ff + 3'd1;
         if (gcnt_ff == 3'd7) begin
            for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
            w_ff[15] <= {gather_ff[55:0], rd_byte_ff};
         end
      end else if (ctrl.cmd == CMD_ROUND) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_new;
      end
      if (ctrl.cmd != CMD_LOAD) gcnt_ff <= '0;
   end

   // Working registers and hash words.
   always_ff @(posedge clock) begin
      if (reset || ctrl.cmd == CMD_RESTART) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= init_hash(3'(i));
      end else if (ctrl.cmd == CMD_ADD) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + r_ff[i];
      end
      if (ctrl.cmd == CMD_LOAD) begin
         for (int i = 0; i < 8; i++) r_ff[i] <= h_ff[i];
      end else if (ctrl.cmd == CMD_ROUND) begin
         r_ff[7] <= r_ff[6];
         r_ff[6] <= r_ff[5];
         r_ff[5] <= r_ff[4];
         r_ff[4] <= r_ff[3] + t1;
         r_ff[3] <= r_ff[2];
         r_ff[2] <= r_ff[1];
         r_ff[1] <= r_ff[0];
         r_ff[0] <= t1 + t2;
      end
   end

   assign digest_out = h_ff[ctrl.out_sel];

endmodule

// ===== src/shash_controller.sv =====
// Controller: sequences absorb, padding, compression and digest output.
module shash_controller
   import shash_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   shash_req_if.sink      req,
   shash_rsp_if.source    rsp,
   input  word_type       digest_in,
   output dp_ctrl_type    ctrl
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_PAD, ST_LOAD, ST_ROUND, ST_ADD, ST_EMIT, ST_RESTART
   } state_type;

   state_type   state_ff, state_in;
   logic [7:0]  fill_ff, fill_in;     // bytes buffered, or pad write pointer
   logic [127:0] len_ff, len_in;      // bits in compressed blocks
   logic [127:0] flen_ff, flen_in;    // final length written into the padding
   logic        final_ff, final_in;   // message is being finalised
   logic        last_blk_ff, last_blk_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic [2:0]  sel_ff, sel_in;
   logic        ovalid_ff, ovalid_in;
   word_type    oword_ff, oword_in;
   dp_ctrl_type c;

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = ovalid_ff;
   assign rsp.digest_word = oword_ff;
   assign rsp.word_index  = sel_ff;
   assign rsp.last_word   = (sel_ff == 3'd7);
   assign ctrl = c;

   // Padding byte for the current pointer.
   logic [7:0] pad_byte;
   logic [6:0] lb;
   always_comb begin
      lb = 7'(fill_ff[6:0] - 7'(LenBytes));
      if (fill_ff[7]) pad_byte = PadByte;   // flag: first pad byte
      else if (last_blk_ff && fill_ff[6:0] >= 7'(LenBytes))
         pad_byte = flen_ff[8'(127 - 8*lb) -: 8];
      else pad_byte = 8'h00;
   end

   always_comb begin
      state_in = state_ff; fill_in = fill_ff; len_in = len_ff; flen_in = flen_ff;
      final_in = final_ff; last_blk_in = last_blk_ff; cnt_in = cnt_ff;
      sel_in = sel_ff; ovalid_in = ovalid_ff; oword_in = oword_ff;
      c = '{cmd: CMD_IDLE, addr: fill_ff[6:0], wdata: req.byte_value,
            round: cnt_ff[6:0], out_sel: sel_ff};
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               if (!req.action) begin
                  c.cmd = CMD_WRITE;
                  if (fill_ff[6:0] == 7'd127) begin
                     fill_in = '0; final_in = 1'b0; state_in = ST_LOAD; cnt_in = '0;
                  end else fill_in = fill_ff + 8'd1;
               end else begin
                  flen_in = len_ff + {118'd0, fill_ff[6:0], 3'd0};
                  final_in = 1'b1;
                  last_blk_in = (fill_ff[6:0] < 7'(LenBytes));
                  fill_in = {1'b1, fill_ff[6:0]};
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            c.cmd = CMD_WRITE; c.wdata = pad_byte;
            fill_in = {1'b0, 7'(fill_ff[6:0] + 7'd1)};
            if (fill_ff[6:0] == 7'd127) begin
               state_in = ST_LOAD; cnt_in = '0;
            end
         end
         ST_LOAD: begin
            // The registered buffer read comes first, then 128 byte reads are gathered.
            c.cmd = CMD_LOAD;
            cnt_in = cnt_ff + 8'd1;
            if (cnt_ff == 8'd128) begin state_in = ST_ROUND; cnt_in = '0; end
         end
         ST_ROUND: begin
            c.cmd = CMD_ROUND;
            cnt_in = cnt_ff + 8'd1;
            if (cnt_ff == 8'(Rounds - 1)) state_in = ST_ADD;
         end
         ST_ADD: begin
            c.cmd = CMD_ADD;
            if (!final_ff) begin
               len_in = len_ff + 128'd1024; state_in = ST_IDLE;
            end else if (!last_blk_ff) begin
               last_blk_in = 1'b1; fill_in = '0; state_in = ST_PAD;
            end else begin
               sel_in = '0; state_in = ST_EMIT; cnt_in = '0;
            end
         end
         ST_EMIT: begin
            // Present one digest word at a time.
            c.out_sel = sel_ff;
            if (!ovalid_ff) begin
               ovalid_in = 1'b1; oword_in = digest_in;
            end else if (rsp.ready) begin
               ovalid_in = 1'b0;
               if (sel_ff == 3'd7) state_in = ST_RESTART;
               else sel_in = sel_ff + 3'd1;
            end
         end
         ST_RESTART: begin
            c.cmd = CMD_RESTART;
            fill_in = '0; len_in = '0; final_in = 1'b0; sel_in = '0;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; fill_ff <= '0; len_ff <= '0; final_ff <= 1'b0;
         last_blk_ff <= 1'b0; cnt_ff <= '0; sel_ff <= '0; ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; fill_ff <= fill_in; len_ff <= len_in;
         final_ff <= final_in; last_blk_ff <= last_blk_in; cnt_ff <= cnt_in;
         sel_ff <= sel_in; ovalid_ff <= ovalid_in;
      end
      flen_ff <= flen_in;
      oword_ff <= oword_in;
   end

endmodule

// ===== tb/sv/sha512_stream_hasher_tb.sv =====
// Self-checking testbench for the SHA-512 byte-stream hasher.
`timescale 1ns / 100ps

module sha512_stream_hasher_tb
   import shash_pkg::*;
();

   localparam int unsigned ActAbsorb   = 0;
   localparam int unsigned ActFinalise = 1;
   localparam int unsigned CycleLimit  = 2000000;

   typedef struct packed {
      logic       action;
      logic [7:0] byte_value;
   } byte_cmd_type;

   typedef struct packed {
      logic [63:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   shash_req_if req ();
   shash_rsp_if rsp ();

   sha512_stream_hasher u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   byte_cmd_type   pending_bytes[$];
   digest_out_type expected_words[$];

   // Predictor state for the message being hashed.
   logic [63:0]  chain[8];
   logic [7:0]   msg_block[128];
   int unsigned  msg_fill;
   logic [127:0] msg_bits;

   int unsigned error_count  = 0;
   int unsigned digest_count = 0;
   int unsigned byte_count   = 0;
   int unsigned cycle_count  = 0;
   bit          quiet_phase  = 1'b0;
   bit          req_taken_ff = 1'b0;

   // Clock generation.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [63:0] rotr(logic [63:0] v, int unsigned s);
      return (v >> s) | (v << (64 - s));
   endfunction

   // One 80-round compression of the message block into the chaining value.
   task automatic compress_msg_block();
      logic [63:0] w[80];
      logic [63:0] r[8];
      logic [63:0] t1, t2, a, e, p, q;
      for (int i = 0; i < 16; i++) begin
         w[i] = '0;
         for (int j = 0; j < 8; j++) w[i] = {w[i][55:0], msg_block[i*8+j]};
      end
      for (int i = 16; i < 80; i++) begin
         p = w[i-2];
         q = w[i-15];
         w[i] = (rotr(p, 19) ^ rotr(p, 61) ^ (p >> 6)) + w[i-7]
              + (rotr(q, 1) ^ rotr(q, 8) ^ (q >> 7)) + w[i-16];
      end
      for (int i = 0; i < 8; i++) r[i] = chain[i];
      for (int i = 0; i < 80; i++) begin
         a = r[0];
         e = r[4];
         t1 = r[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41))
            + ((e & r[5]) ^ (~e & r[6])) + round_const(7'(i)) + w[i];
         t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39))
            + ((a & r[1]) ^ (a & r[2]) ^ (r[1] & r[2]));
         for (int k = 7; k > 0; k--) r[k] = r[k-1];
         r[4] = r[4] + t1;
         r[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += r[i];
   endtask

   task automatic restart_digest();
      for (int i = 0; i < 8; i++) chain[i] = init_hash(3'(i));
      msg_fill = 0;
      msg_bits = '0;
   endtask

   // Work out the digest words, if any, that one accepted word causes.
   task automatic predict_digest(byte_cmd_type c);
      logic [127:0]   len;
      int unsigned    pos;
      digest_out_type d;
      if (c.action == 1'(ActAbsorb)) begin
         msg_block[msg_fill] = c.byte_value;
         msg_fill++;
         if (msg_fill == BlockBytes) begin
            compress_msg_block();
            msg_bits += 128'd1024;
            msg_fill = 0;
         end
         return;
      end
      len = msg_bits + 128'(msg_fill * 8);
      pos = msg_fill;
      msg_block[pos] = PadByte;
      pos++;
      if (pos > LenBytes) begin
         while (pos < BlockBytes) msg_block[pos++] = 8'h00;
         compress_msg_block();
         pos = 0;
      end
      while (pos < LenBytes) msg_block[pos++] = 8'h00;
      for (int i = 0; i < 16; i++) msg_block[127-i] = len[i*8 +: 8];
      compress_msg_block();
      for (int i = 0; i < 8; i++) begin
         d.digest_word = chain[i];
         d.word_index  = 3'(i);
         d.last_word   = (i == 7);
         expected_words.push_back(d);
      end
      restart_digest();
   endtask

   task automatic queue_message(int unsigned n_bytes, bit all_ones);
      byte_cmd_type c;
      for (int i = 0; i < n_bytes; i++) begin
         c.action     = 1'(ActAbsorb);
         c.byte_value = all_ones ? 8'hff : 8'($urandom_range(0, 255));
         pending_bytes.push_back(c);
      end
      c.action     = 1'(ActFinalise);
      c.byte_value = 8'($urandom_range(0, 255));
      pending_bytes.push_back(c);
   endtask

   // Driver: presents words at the falling edge, idling at random outside the quiet phase.
   initial begin
      req.valid      = 1'b0;
      req.action     = 1'b0;
      req.byte_value = 8'h00;
   end

   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req_taken_ff) begin
         if (pending_bytes.size() != 0 && (quiet_phase || $urandom_range(0, 99) >= 32)) begin
            req.valid      <= 1'b1;
            req.action     <= pending_bytes[0].action;
            req.byte_value <= pending_bytes[0].byte_value;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Accepted words feed the predictor; the queue is popped on acceptance.
   always @(posedge clock) begin
      req_taken_ff <= !reset && req.valid && req.ready;
      if (!reset && req.valid && req.ready) begin
         predict_digest(byte_cmd_type'{req.action, req.byte_value});
         void'(pending_bytes.pop_front());
         byte_count++;
      end
   end

   // Monitor: response stalls and comparison against the oldest expectation.
   initial rsp.ready = 1'b0;

   always @(negedge clock) begin
      rsp.ready <= !reset && (quiet_phase || $urandom_range(0, 99) >= 32);
   end

   always @(posedge clock) begin
      digest_out_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected digest word %h", rsp.digest_word);
            error_count++;
         end else begin
            e = expected_words.pop_front();
            if (rsp.digest_word !== e.digest_word) begin
               $error("digest_word expected %h got %h", e.digest_word, rsp.digest_word);
               error_count++;
            end
            if (rsp.word_index !== e.word_index) begin
               $error("word_index expected %0d got %0d", e.word_index, rsp.word_index);
               error_count++;
            end
            if (rsp.last_word !== e.last_word) begin
               $error("last_word expected %0d got %0d", e.last_word, rsp.last_word);
               error_count++;
            end
            if (e.last_word) digest_count++;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("sha512_stream_hasher_tb NOT OK");
         $finish;
      end
   end

   // Stimulus and end of run.
   initial begin
      restart_digest();
      for (int i = 0; i < 128; i++) msg_block[i] = 8'h00;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty message, single extreme bytes, short messages.
      queue_message(0, 1'b0);
      pending_bytes.push_back(byte_cmd_type'{1'(ActAbsorb), 8'h00});
      pending_bytes.push_back(byte_cmd_type'{1'(ActFinalise), 8'hff});
      pending_bytes.push_back(byte_cmd_type'{1'(ActAbsorb), 8'hff});
      pending_bytes.push_back(byte_cmd_type'{1'(ActFinalise), 8'h00});
      queue_message(3, 1'b1);
      queue_message(10, 1'b0);
      wait (pending_bytes.size() == 0);

      // A message long enough to push the length into a second padding block.
      queue_message(112 + $urandom_range(0, 4), 1'b0);
      wait (pending_bytes.size() == 0);

      // A message across a block boundary, sent with no idling at all.
      quiet_phase = 1'b1;
      queue_message($urandom_range(128, 132), 1'b0);
      wait (pending_bytes.size() == 0);
      quiet_phase = 1'b0;

      wait (expected_words.size() == 0);
      repeat (600) @(posedge clock);
      $display("Hashed %0d request words into %0d digests, random idling on both channels.",
               byte_count, digest_count);
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("sha512_stream_hasher_tb OK");
      end else begin
         $display("sha512_stream_hasher_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/shash_pkg.sv
src/shash_if.sv
src/shash_datapath.sv
src/shash_controller.sv
src/sha512_stream_hasher.sv
tb/sv/sha512_stream_hasher_tb.sv
